>>> design/assert_macros.svh
// Assertion macros shared by the RTL. Bodies are empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// Consequence that must hold in the same cycle as its antecedent.
`define CHK_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequence that must hold in the cycle after its antecedent.
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define CHK_ALWAYS(name, clk, rst, expr)
`define CHK_IMPLY(name, clk, rst, ante, cons)
`define CHK_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> design/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam int BUFFER_DEPTH_DEF = 16;
   localparam logic [4:0] POS_MAX = 5'd31;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_LAUNCH = 2'd1,
      FUNC_EVENT  = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_SEND    = 3'd2,
      ACT_RX_ACK  = 3'd3,
      ACT_RX_NACK = 3'd4,
      ACT_STOP    = 3'd5,
      ACT_ABANDON = 3'd6
   } action_type;

   // Bus engine status codes; anything above ST_OTHER is treated as ST_OTHER.
   localparam logic [3:0] ST_START        = 4'd0;
   localparam logic [3:0] ST_RSTART       = 4'd1;
   localparam logic [3:0] ST_WR_ADDR_ACK  = 4'd2;
   localparam logic [3:0] ST_WR_DATA_ACK  = 4'd3;
   localparam logic [3:0] ST_RD_ADDR_ACK  = 4'd4;
   localparam logic [3:0] ST_RD_DATA_ACK  = 4'd5;
   localparam logic [3:0] ST_RD_DATA_NACK = 4'd6;
   localparam logic [3:0] ST_ARB_LOST     = 4'd7;
   localparam logic [3:0] ST_WR_ADDR_NACK = 4'd8;
   localparam logic [3:0] ST_RD_ADDR_NACK = 4'd9;
   localparam logic [3:0] ST_WR_DATA_NACK = 4'd10;
   localparam logic [3:0] ST_BUS_ERROR    = 4'd11;
   localparam logic [3:0] ST_OTHER        = 4'd12;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_WR_ADDR_NACK = 3'd1;
   localparam logic [2:0] ERR_RD_ADDR_NACK = 3'd2;
   localparam logic [2:0] ERR_WR_DATA_NACK = 3'd3;
   localparam logic [2:0] ERR_BUS          = 3'd4;
   localparam logic [2:0] ERR_OTHER        = 3'd5;

   typedef struct packed {
      func_type   func;
      logic [3:0] buf_index;
      logic [7:0] wr_byte;
      logic [6:0] target_addr;
      logic       read_not_write;
      logic [4:0] msg_len;
      logic [3:0] status;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] tx_byte;
      logic [7:0] read_byte;
      logic       busy_res;
      logic [2:0] last_error;
      logic       rejected;
   } rsp_type;

   // Buffer position advances by one and sticks at its top value.
   function automatic logic [4:0] pos_inc(input logic [4:0] pos);
      pos_inc = (pos == POS_MAX) ? pos : pos + 5'd1;
   endfunction

endpackage

>>> design/i2c_master_transfer_sequencer_top.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle unless the result side stalls (single processing stage).
// Reset: synchronous, active high; holds ready low and clears both stage valids and all state.
// The byte buffer is not cleared by reset; an entry reads back as whatever was last written.
`include "assert_macros.svh"

module i2c_master_transfer_sequencer_top import i2cms_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Address width of the buffer, and a nine-bit width that holds any legal depth
   // so that positions and indexes can be range-checked without truncation.
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int IW = 9;
   localparam logic [IW-1:0] DEPTH_W = IW'(BUFFER_DEPTH);

   // The pipeline has two registers. The input register holds one accepted item
   // while the buffer is read for it; the processing stage then applies the item
   // to the sequencer state and writes the result register. An item moves on
   // whenever the result register is empty or is being emptied in the same cycle,
   // so a new item is taken in every cycle unless the result side stalls.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    fire;
   logic    load;

   // Sequencer state.
   logic [4:0] pos_ff, pos_in;
   logic       addr_sent_ff, addr_sent_in;
   logic [7:0] addr_ff, addr_in;
   logic [4:0] length_ff, length_in;
   logic       busy_ff, busy_in;
   logic [2:0] err_ff, err_in;

   // Buffer access.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    ram_rd_data;
   logic [7:0]    mem_data;
   logic          byp_hit_ff;
   logic [7:0]    byp_data_ff;
   logic [4:0]    pos_fwd;
   logic [IW-1:0] req_idx_w;
   logic [IW-1:0] pos_fwd_w;

   // Working values of the processing stage.
   logic [IW-1:0] s1_idx_w;
   logic          idx_ok;
   logic [IW-1:0] pos_w;
   logic          pos_ok;
   logic [4:0]    ev_pos;
   logic          ev_sent;
   logic [IW-1:0] ev_pos_w;
   logic [4:0]    launch_len;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || fire);
   assign load      = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The buffer read for an incoming item is issued as it enters the input
   // register. The item ahead of it may change the position or write the buffer
   // at that same edge, so the position is forwarded from the processing stage and
   // a write to the address being read is caught in a bypass register.
   assign pos_fwd   = fire ? pos_in : pos_ff;
   assign req_idx_w = IW'(req_data.buf_index);
   assign pos_fwd_w = IW'(pos_fwd);
   assign rd_addr   = (req_data.func == FUNC_READ) ? req_idx_w[AW-1:0] : pos_fwd_w[AW-1:0];
   assign mem_data  = byp_hit_ff ? byp_data_ff : ram_rd_data;

   i2cms_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (load),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         addr_sent_ff <= 1'b0;
         addr_ff      <= '0;
         length_ff    <= '0;
         busy_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pos_ff       <= pos_in;
            addr_sent_ff <= addr_sent_in;
            addr_ff      <= addr_in;
            length_ff    <= length_in;
            busy_ff      <= busy_in;
            err_ff       <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_data_ff  <= req_data;
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Range checks on the item's index and the current buffer position.
   assign s1_idx_w = IW'(s1_data_ff.buf_index);
   assign idx_ok   = s1_idx_w < DEPTH_W;
   assign pos_w    = IW'(pos_ff);
   assign pos_ok   = pos_w < DEPTH_W;
   assign ev_pos_w = IW'(ev_pos);

   // Launch length is clamped to the buffer depth, and a read moves at least one byte.
   always_comb begin
      launch_len = s1_data_ff.msg_len;
      if (IW'(s1_data_ff.msg_len) > DEPTH_W) begin
         launch_len = DEPTH_W[4:0];
      end
      if (s1_data_ff.read_not_write && (launch_len == 5'd0)) begin
         launch_len = 5'd1;
      end
   end

   // Processing stage: one item against the sequencer state.
   always_comb begin
      pos_in       = pos_ff;
      addr_sent_in = addr_sent_ff;
      addr_in      = addr_ff;
      length_in    = length_ff;
      busy_in      = busy_ff;
      err_in       = err_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_w[AW-1:0];
      wr_data      = s1_data_ff.rx_byte;
      ev_pos       = pos_ff;
      ev_sent      = addr_sent_ff;
      rsp_in       = '0;
      rsp_in.action = ACT_NONE;

      case (s1_data_ff.func)
         FUNC_LOAD: begin
            if (busy_ff) begin
               rsp_in.rejected = 1'b1;
            end else if (idx_ok) begin
               wr_en   = 1'b1;
               wr_addr = s1_idx_w[AW-1:0];
               wr_data = s1_data_ff.wr_byte;
            end
         end
         FUNC_LAUNCH: begin
            if (busy_ff) begin
               rsp_in.rejected = 1'b1;
            end else begin
               length_in     = launch_len;
               addr_in       = {s1_data_ff.target_addr, s1_data_ff.read_not_write};
               err_in        = ERR_NONE;
               busy_in       = 1'b1;
               rsp_in.action = ACT_START;
            end
         end
         FUNC_EVENT: begin
            if (busy_ff) begin
               case (s1_data_ff.status)
                  ST_START, ST_RSTART, ST_WR_ADDR_ACK, ST_WR_DATA_ACK: begin
                     // A (repeated) start begins the transfer again from the address.
                     if (s1_data_ff.status inside {ST_START, ST_RSTART}) begin
                        ev_pos  = 5'd0;
                        ev_sent = 1'b0;
                     end
                     pos_in       = ev_pos;
                     addr_sent_in = ev_sent;
                     if (!ev_sent) begin
                        addr_sent_in   = 1'b1;
                        rsp_in.tx_byte = addr_ff;
                        rsp_in.action  = ACT_SEND;
                     end else if ((ev_pos < length_ff) && (ev_pos_w < DEPTH_W)) begin
                        rsp_in.tx_byte = mem_data;
                        pos_in         = pos_inc(ev_pos);
                        rsp_in.action  = ACT_SEND;
                     end else begin
                        busy_in       = 1'b0;
                        rsp_in.action = ACT_STOP;
                     end
                  end
                  ST_RD_DATA_ACK: begin
                     wr_en  = pos_ok;
                     ev_pos = pos_inc(pos_ff);
                     pos_in = ev_pos;
                     // Acknowledge while at least two more bytes are due.
                     rsp_in.action = ((6'(ev_pos) + 6'd1) < 6'(length_ff)) ?
                                     ACT_RX_ACK : ACT_RX_NACK;
                  end
                  ST_RD_ADDR_ACK: begin
                     rsp_in.action = ((6'(pos_ff) + 6'd1) < 6'(length_ff)) ?
                                     ACT_RX_ACK : ACT_RX_NACK;
                  end
                  ST_RD_DATA_NACK: begin
                     wr_en         = pos_ok;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_STOP;
                  end
                  ST_ARB_LOST: begin
                     rsp_in.action = ACT_START;
                  end
                  ST_WR_ADDR_NACK: begin
                     err_in        = ERR_WR_ADDR_NACK;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_ABANDON;
                  end
                  ST_RD_ADDR_NACK: begin
                     err_in        = ERR_RD_ADDR_NACK;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_ABANDON;
                  end
                  ST_WR_DATA_NACK: begin
                     err_in        = ERR_WR_DATA_NACK;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_ABANDON;
                  end
                  ST_BUS_ERROR: begin
                     err_in        = ERR_BUS;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_ABANDON;
                  end
                  default: begin
                     err_in        = ERR_OTHER;
                     busy_in       = 1'b0;
                     rsp_in.action = ACT_ABANDON;
                  end
               endcase
            end
         end
         FUNC_READ: begin
            if (idx_ok) begin
               rsp_in.read_byte = mem_data;
            end
         end
         default: begin
            rsp_in.action = ACT_NONE;
         end
      endcase

      // The buffer is only written when the item actually leaves the input register;
      // an item that waits, or one that has already gone, must not write again.
      if (!fire) begin
         wr_en = 1'b0;
      end

      rsp_in.busy_res   = busy_in;
      rsp_in.last_error = err_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The input side only stalls when both registers are full.
   `CHK_IMPLY(a_ready_stall, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff)
   // A refused load or launch is only possible during a transfer.
   `CHK_IMPLY(a_reject_busy, clock, reset, fire && rsp_in.rejected, busy_ff)
   // An accepted launch leaves the sequencer busy with the error cleared.
   `CHK_NEXT(a_launch_busy, clock, reset,
             fire && (rsp_in.action == ACT_START) && !busy_ff,
             busy_ff && (err_ff == ERR_NONE))
   // Stop and abandon always end the transfer.
   `CHK_NEXT(a_end_idle, clock, reset,
             fire && ((rsp_in.action == ACT_STOP) || (rsp_in.action == ACT_ABANDON)),
             !busy_ff)

endmodule

>>> design/i2cms_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
